### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on aclk and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RQF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RQF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rqf_pkg.sv
// ----------------------------------------------------------------------------
// rqf_pkg
// Widths, codes and controller/datapath interface types of the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rqf_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int CONN_W     = 16;
    localparam int SIZE_W     = 31;
    localparam int DRAW_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int POLICY_W   = 2;
    localparam int CAP_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [POLICY_W-1:0] POL_FIFO   = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SSF    = 2'd1;
    localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 4'd1;

    typedef enum logic [1:0] {
        RA_TAILDEC,
        RA_PICK,
        RA_RDDEC
    } rdsel_t;

    typedef enum logic [1:0] {
        COMMIT_NONE,
        COMMIT_ENQ,
        COMMIT_DEQ
    } commit_t;

    typedef struct packed {
        logic                load_item;
        logic                mod_start;
        logic                rd_en;
        rdsel_t              rd_sel;
        logic                wr_en;
        logic                wr_new;
        logic                wr_at_tail;
        logic                set_wr_tail;
        logic                wr_from_rd;
        logic                n_load;
        logic                n_dec;
        logic                take_out;
        logic                fin;
        logic [STATUS_W-1:0] fin_status;
        commit_t             fin_commit;
    } rqf_cmd_t;

    typedef struct packed {
        logic                is_deq;
        logic                full;
        logic                empty;
        logic [POLICY_W-1:0] policy;
        logic                size_le;
        logic                n_one;
        logic                rd_at_head;
        logic                mod_done;
        logic                out_free;
    } rqf_sts_t;

endpackage

`default_nettype wire

### rtl/rqf_mod.sv
// ----------------------------------------------------------------------------
// rqf_mod
// Restoring remainder unit: draw mod count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rqf_mod #(
    parameter int VW = 5
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [rqf_pkg::DRAW_W-1:0] dividend,
    input  wire logic [VW-1:0]             divisor,
    output logic                           done,
    output logic [VW-1:0]                  rem
);

    localparam int DW = rqf_pkg::DRAW_W;
    localparam int SW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [DW-1:0] num_reg;
    logic [VW-1:0] rem_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic [VW-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, num_reg[DW-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = (trial >= {1'b0, divisor}) ? diff[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == SW'(DW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            num_reg  <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + SW'(1);
            num_reg  <= {num_reg[DW-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### rtl/rqf_dpath.sv
// ----------------------------------------------------------------------------
// rqf_dpath
// Entry memory, ring pointers, config registers, item and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rqf_dpath #(
    parameter int DEPTH = rqf_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rqf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rqf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          s_tuser,
    input  wire logic [rqf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                          m_tready,
    input  wire rqf_pkg::rqf_cmd_t             cmd,
    output rqf_pkg::rqf_sts_t                  sts,
    output logic                               m_tvalid,
    output logic [rqf_pkg::STATUS_W-1:0]       m_tuser,
    output logic [rqf_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CW1    = CW + 1;
    localparam int CONN_W = rqf_pkg::CONN_W;
    localparam int SIZE_W = rqf_pkg::SIZE_W;
    localparam int OCC_W  = rqf_pkg::OCC_W;
    localparam int EW     = CONN_W + SIZE_W;
    localparam int PAD_W  = rqf_pkg::M_TDATA_W - EW - OCC_W;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] a,
                                              input logic [CW-1:0] cap);
        logic [CW1-1:0] s;
        s = CW1'(a) + CW1'(1);
        if (s >= CW1'(cap)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = PW'(s);
        end
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] a,
                                              input logic [CW-1:0] cap);
        if (a == '0) begin
            ptr_dec = PW'(cap - CW'(1));
        end else begin
            ptr_dec = a - PW'(1);
        end
    endfunction

    logic [rqf_pkg::POLICY_W-1:0] policy_reg;
    logic [rqf_pkg::CAP_W-1:0]    capacity_reg;
    logic [PW-1:0]                head_reg;
    logic [PW-1:0]                tail_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                cap_eff;

    logic                         item_cmd_reg;
    logic [CONN_W-1:0]            item_conn_reg;
    logic [SIZE_W-1:0]            item_size_reg;
    logic [rqf_pkg::DRAW_W-1:0]   item_draw_reg;

    logic [EW-1:0]                mem [DEPTH];
    logic [EW-1:0]                rdata_reg;
    logic [PW-1:0]                rd_reg;
    logic [PW-1:0]                wr_reg;
    logic [CW-1:0]                n_reg;
    logic [CONN_W-1:0]            hold_conn_reg;
    logic [SIZE_W-1:0]            hold_size_reg;

    logic                         m_valid_reg;
    logic [rqf_pkg::STATUS_W-1:0] out_status_reg;
    logic [CONN_W-1:0]            out_conn_reg;
    logic [SIZE_W-1:0]            out_size_reg;
    logic [OCC_W-1:0]             out_occ_reg;

    logic [CW-1:0]                rem;
    logic [CW1-1:0]               psum;
    logic [PW-1:0]                pick;
    logic [PW-1:0]                rd_addr;
    logic [PW-1:0]                wr_addr;
    logic [EW-1:0]                wr_data;
    logic [CW+OCC_W-1:0]          occ_ext;

    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CW'(1);
        end else if (int'(capacity_reg) > DEPTH) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(capacity_reg);
        end
    end

    always_comb begin
        psum = CW1'(head_reg) + CW1'(rem);
        if (psum >= CW1'(cap_eff)) begin
            psum = psum - CW1'(cap_eff);
        end
        pick = (policy_reg == rqf_pkg::POL_RANDOM) ? PW'(psum) : head_reg;
    end

    always_comb begin
        case (cmd.rd_sel)
            rqf_pkg::RA_TAILDEC: rd_addr = ptr_dec(tail_reg, cap_eff);
            rqf_pkg::RA_PICK:    rd_addr = pick;
            rqf_pkg::RA_RDDEC:   rd_addr = ptr_dec(rd_reg, cap_eff);
            default:             rd_addr = head_reg;
        endcase
    end

    assign wr_addr = cmd.wr_at_tail ? tail_reg : wr_reg;
    assign wr_data = cmd.wr_new ? {item_size_reg, item_conn_reg} : rdata_reg;

    always_comb begin
        case (cmd.fin_commit)
            rqf_pkg::COMMIT_ENQ: count_next = count_reg + CW'(1);
            rqf_pkg::COMMIT_DEQ: count_next = count_reg - CW'(1);
            default:             count_next = count_reg;
        endcase
        occ_ext = {OCC_W'(0), count_next};
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg   <= rqf_pkg::POL_FIFO;
            capacity_reg <= rqf_pkg::CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == rqf_pkg::REG_POLICY) begin
                policy_reg <= cfg_data[rqf_pkg::POLICY_W-1:0];
            end else if (cfg_we && cfg_index == rqf_pkg::REG_CAPACITY) begin
                capacity_reg <= cfg_data;
                head_reg     <= '0;
                tail_reg     <= '0;
                count_reg    <= '0;
            end else if (cmd.fin) begin
                count_reg <= count_next;
                if (cmd.fin_commit == rqf_pkg::COMMIT_ENQ) begin
                    tail_reg <= ptr_inc(tail_reg, cap_eff);
                end
                if (cmd.fin_commit == rqf_pkg::COMMIT_DEQ) begin
                    head_reg <= ptr_inc(head_reg, cap_eff);
                end
            end
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg  <= s_tuser;
            item_conn_reg <= s_tdata[CONN_W-1:0];
            item_size_reg <= s_tdata[EW-1:CONN_W];
            item_draw_reg <= s_tdata[EW+rqf_pkg::DRAW_W-1:EW];
            hold_conn_reg <= '0;
            hold_size_reg <= '0;
        end else if (cmd.take_out) begin
            hold_conn_reg <= rdata_reg[CONN_W-1:0];
            hold_size_reg <= rdata_reg[EW-1:CONN_W];
        end
        if (cmd.rd_en) begin
            rd_reg <= rd_addr;
        end
        if (cmd.set_wr_tail) begin
            wr_reg <= tail_reg;
        end else if (cmd.wr_from_rd) begin
            wr_reg <= rd_reg;
        end
        if (cmd.n_load) begin
            n_reg <= count_reg;
        end else if (cmd.n_dec) begin
            n_reg <= n_reg - CW'(1);
        end
        if (cmd.fin) begin
            out_status_reg <= cmd.fin_status;
            out_conn_reg   <= hold_conn_reg;
            out_size_reg   <= hold_size_reg;
            out_occ_reg    <= occ_ext[OCC_W-1:0];
        end
    end

    rqf_mod #(
        .VW(CW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .dividend(item_draw_reg),
        .divisor (count_reg),
        .done    (sts.mod_done),
        .rem     (rem)
    );

    assign sts.is_deq     = (item_cmd_reg == rqf_pkg::CMD_DEQ);
    assign sts.full       = (count_reg >= cap_eff);
    assign sts.empty      = (count_reg == '0);
    assign sts.policy     = policy_reg;
    assign sts.size_le    = (rdata_reg[EW-1:CONN_W] <= item_size_reg);
    assign sts.n_one      = (n_reg == CW'(1));
    assign sts.rd_at_head = (rd_reg == head_reg);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {PAD_W'(0), out_occ_reg, out_size_reg, out_conn_reg};

endmodule

`default_nettype wire

### rtl/rqf_ctrl.sv
// ----------------------------------------------------------------------------
// rqf_ctrl
// Sequencer for one queue operation: decide, shift entries, post the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rqf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire rqf_pkg::rqf_sts_t sts,
    output rqf_pkg::rqf_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS,
        S_INS_LAST,
        S_MOD,
        S_PICK,
        S_SHIFT,
        S_FIN
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [rqf_pkg::STATUS_W-1:0] fin_status_reg;
    logic [rqf_pkg::STATUS_W-1:0] fin_status_next;
    rqf_pkg::commit_t             fin_commit_reg;
    rqf_pkg::commit_t             fin_commit_next;

    always_comb begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        fin_commit_next = fin_commit_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!sts.is_deq) begin
                    if (sts.full) begin
                        fin_status_next = rqf_pkg::ST_FULL;
                        fin_commit_next = rqf_pkg::COMMIT_NONE;
                        state_next      = S_FIN;
                    end else if (sts.policy == rqf_pkg::POL_SSF && !sts.empty) begin
                        cmd.n_load      = 1'b1;
                        cmd.set_wr_tail = 1'b1;
                        cmd.rd_en       = 1'b1;
                        cmd.rd_sel      = rqf_pkg::RA_TAILDEC;
                        state_next      = S_INS;
                    end else begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_new      = 1'b1;
                        cmd.wr_at_tail  = 1'b1;
                        fin_status_next = rqf_pkg::ST_DONE;
                        fin_commit_next = rqf_pkg::COMMIT_ENQ;
                        state_next      = S_FIN;
                    end
                end else begin
                    if (sts.empty) begin
                        fin_status_next = rqf_pkg::ST_EMPTY;
                        fin_commit_next = rqf_pkg::COMMIT_NONE;
                        state_next      = S_FIN;
                    end else if (sts.policy == rqf_pkg::POL_RANDOM) begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MOD;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = rqf_pkg::RA_PICK;
                        state_next = S_PICK;
                    end
                end
            end
            S_INS: begin
                cmd.wr_en = 1'b1;
                if (sts.size_le) begin
                    cmd.wr_new      = 1'b1;
                    fin_status_next = rqf_pkg::ST_DONE;
                    fin_commit_next = rqf_pkg::COMMIT_ENQ;
                    state_next      = S_FIN;
                end else begin
                    cmd.wr_from_rd = 1'b1;
                    cmd.n_dec      = 1'b1;
                    if (sts.n_one) begin
                        state_next = S_INS_LAST;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = rqf_pkg::RA_RDDEC;
                    end
                end
            end
            S_INS_LAST: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_new      = 1'b1;
                fin_status_next = rqf_pkg::ST_DONE;
                fin_commit_next = rqf_pkg::COMMIT_ENQ;
                state_next      = S_FIN;
            end
            S_MOD: begin
                if (sts.mod_done) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rqf_pkg::RA_PICK;
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                cmd.take_out    = 1'b1;
                fin_status_next = rqf_pkg::ST_DONE;
                fin_commit_next = rqf_pkg::COMMIT_DEQ;
                if (sts.rd_at_head) begin
                    state_next = S_FIN;
                end else begin
                    cmd.wr_from_rd = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel     = rqf_pkg::RA_RDDEC;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_from_rd = 1'b1;
                if (sts.rd_at_head) begin
                    state_next = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rqf_pkg::RA_RDDEC;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = fin_status_reg;
                    cmd.fin_commit = fin_commit_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fin_status_reg <= rqf_pkg::ST_DONE;
            fin_commit_reg <= rqf_pkg::COMMIT_NONE;
        end else begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
            fin_commit_reg <= fin_commit_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### rtl/request_queue_fifo_sff_random_top.sv
// ----------------------------------------------------------------------------
// request_queue_fifo_sff_random_top
// Bounded request queue with first-in first-out, shortest-first and random
// pick scheduling.
//
// s_ channel: one command per item; s_tuser is the command (enqueue or
//   dequeue), s_tdata carries connection id, job size and a random draw.
// m_ channel: exactly one result per command; m_tuser is the status,
//   m_tdata carries the dequeued entry and the occupancy afterwards.
// cfg channel: policy (index 0) and capacity (index 1); always ready.
//   Writing capacity empties the queue. Write only while no command is open.
// Path from accept to m_tvalid: a plain enqueue or a refused command goes
//   from decide straight to the result, a head dequeue reads the head first,
//   a shortest-first enqueue into a non-empty queue moves entries one at a
//   time, a random dequeue runs the 16-step remainder unit, then reads the
//   pick and shifts entries toward the head. One command at a time: s_tready
//   returns the cycle after the result is posted.
// Reset (synchronous aresetn) empties the queue, policy first-in first-out,
//   capacity 16. A stalled receiver holds the result and the next command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module request_queue_fifo_sff_random_top #(
    parameter int DEPTH = rqf_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rqf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rqf_pkg::CFG_DATA_W-1:0] cfg_data,
    // command channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tuser: cmd
    input  wire logic                          s_tuser,
    // s_tdata: conn_id[15:0], job_size[46:16], random_draw[62:47], zero[63]
    input  wire logic [rqf_pkg::S_TDATA_W-1:0]  s_tdata,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tuser: status
    output logic [rqf_pkg::STATUS_W-1:0]       m_tuser,
    // m_tdata: out_conn[15:0], out_size[46:16], occupancy[51:47], zero[55:52]
    output logic [rqf_pkg::M_TDATA_W-1:0]      m_tdata
);

    rqf_pkg::rqf_cmd_t ctl_cmd;
    rqf_pkg::rqf_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    rqf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (dp_sts),
        .cmd     (ctl_cmd)
    );

    rqf_dpath #(
        .DEPTH(DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (ctl_cmd),
        .sts      (dp_sts),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    `RQF_ASSERT_IMP(a_refused_zero, m_tvalid && (m_tuser == rqf_pkg::ST_EMPTY || m_tuser == rqf_pkg::ST_FULL), m_tdata[rqf_pkg::CONN_W+rqf_pkg::SIZE_W-1:0] == '0, "refused command carries entry data")
    `RQF_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "second item accepted while busy")
    `RQF_ASSERT_IMP(a_fin_free, ctl_cmd.fin, !m_tvalid || m_tready, "result posted over a pending one")
    `RQF_ASSERT_IMP(a_mod_nonempty, ctl_cmd.mod_start, !dp_sts.empty, "random pick on an empty queue")

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the request queue. A table of directed commands
// covers reset values, capacity and policy extremes, full and empty refusals
// and the unused policy code. Random phases follow, each with a fresh policy
// and capacity. Every accepted command runs through an in-bench scheduler
// that tracks the ring, and each reply is compared field by field in order.
// The sender works in bursts and the receiver stalls on its own pattern,
// with one long hold-off that backs the queue up into the command channel.
// ----------------------------------------------------------------------------
module tb;
    import rqf_pkg::*;

    localparam int SLOTS = DEPTH_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 4'hF;
    localparam logic [POLICY_W-1:0]  POL_UNUSED = 2'd3;
    localparam logic [CONN_W-1:0]    CONN_MAX   = '1;
    localparam logic [SIZE_W-1:0]    SIZE_MAX   = '1;
    localparam logic [DRAW_W-1:0]    DRAW_MAX   = '1;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic              cmd;
        logic [CONN_W-1:0] conn;
        logic [SIZE_W-1:0] size;
        logic [DRAW_W-1:0] draw;
    } queue_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CONN_W-1:0]   conn;
        logic [SIZE_W-1:0]   size;
        logic [OCC_W-1:0]    occ;
    } reply_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        queue_op_t            req;
        logic                 typed;
        reply_t               want;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
    } row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic                  s_tuser   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [STATUS_W-1:0]   m_tuser;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic [CONN_W-1:0]   shadow_conn [SLOTS];
    logic [SIZE_W-1:0]   shadow_size [SLOTS];
    int unsigned         shadow_head  = 0;
    int unsigned         shadow_tail  = 0;
    int unsigned         shadow_count = 0;
    logic [POLICY_W-1:0] shadow_policy = POL_FIFO;
    logic [CAP_W-1:0]    shadow_cap    = CAP_RESET;

    reply_t pending_replies[$];
    row_t   directed[$];
    int     mismatch_count = 0;
    int     burst_left     = 0;
    bit     hold_req       = 1'b0;
    bit     hold_done      = 1'b0;
    int     hold_left      = 0;
    int     rx_cycle       = 0;
    int     rx_mode        = 0;

    always #10 aclk = ~aclk;

    request_queue_fifo_sff_random_top #(
        .DEPTH(SLOTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),      // cmd
        .s_tdata(s_tdata),      // conn_id, job_size, random_draw, zero pad
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),      // status
        .m_tdata(m_tdata)       // out_conn, out_size, occupancy, zero pad
    );

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == REG_POLICY) begin
            shadow_policy = data[POLICY_W-1:0];
        end else if (idx == REG_CAPACITY) begin
            shadow_cap   = data[CAP_W-1:0];
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_count = 0;
        end
    endfunction

    function automatic reply_t schedule_request(queue_op_t req);
        int unsigned ring, n, dst, src, pick, i, prev;
        reply_t r;
        ring = (shadow_cap == 0) ? 1 : ((shadow_cap > SLOTS) ? SLOTS : shadow_cap);
        r = '0;
        r.status = ST_DONE;
        shadow_head = shadow_head % ring;
        shadow_tail = shadow_tail % ring;
        if (req.cmd == CMD_ENQ) begin
            if (shadow_count >= ring) begin
                r.status = ST_FULL;
            end else if (shadow_policy == POL_SSF) begin
                n = shadow_count;
                while (n > 0 && shadow_size[(shadow_head + n - 1) % ring] > req.size) begin
                    src = (shadow_head + n - 1) % ring;
                    dst = (shadow_head + n) % ring;
                    shadow_conn[dst] = shadow_conn[src];
                    shadow_size[dst] = shadow_size[src];
                    n--;
                end
                dst = (shadow_head + n) % ring;
                shadow_conn[dst] = req.conn;
                shadow_size[dst] = req.size;
                shadow_count++;
                shadow_tail = (shadow_head + shadow_count) % ring;
            end else begin
                shadow_conn[shadow_tail] = req.conn;
                shadow_size[shadow_tail] = req.size;
                shadow_tail = (shadow_tail + 1) % ring;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            pick = shadow_head;
            if (shadow_policy == POL_RANDOM)
                pick = (shadow_head + req.draw % shadow_count) % ring;
            r.conn = shadow_conn[pick];
            r.size = shadow_size[pick];
            for (i = pick; i != shadow_head; i = (i + ring - 1) % ring) begin
                prev = (i + ring - 1) % ring;
                shadow_conn[i] = shadow_conn[prev];
                shadow_size[i] = shadow_size[prev];
            end
            shadow_head = (shadow_head + 1) % ring;
            shadow_count--;
        end
        r.occ = OCC_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t ns mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_reply();
        reply_t want;
        if (pending_replies.size() == 0) begin
            report_mismatch("reply with nothing pending", m_tdata, 0);
        end else begin
            want = pending_replies.pop_front();
            if (m_tuser !== want.status)
                report_mismatch("status", m_tuser, want.status);
            if (m_tdata[15:0] !== want.conn)
                report_mismatch("out_conn", m_tdata[15:0], want.conn);
            if (m_tdata[46:16] !== want.size)
                report_mismatch("out_size", m_tdata[46:16], want.size);
            if (m_tdata[51:47] !== want.occ)
                report_mismatch("occupancy", m_tdata[51:47], want.occ);
        end
    endtask

    // hold valid through a burst, drop it for a gap between most bursts
    task automatic send_request(queue_op_t req, logic typed, reply_t want);
        int gap;
        reply_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= {1'b0, req.draw, req.size, req.conn};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = schedule_request(req);
        pending_replies.push_back(typed ? want : predicted);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic add_item(logic cmd, logic [CONN_W-1:0] conn, logic [SIZE_W-1:0] size,
                            logic [DRAW_W-1:0] draw);
        row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.req  = '{cmd, conn, size, draw};
        directed.push_back(row);
    endtask

    task automatic add_checked(logic cmd, logic [CONN_W-1:0] conn, logic [SIZE_W-1:0] size,
                               logic [DRAW_W-1:0] draw, logic [STATUS_W-1:0] status,
                               logic [CONN_W-1:0] oc, logic [SIZE_W-1:0] os,
                               logic [OCC_W-1:0] occ);
        row_t row;
        row = '0;
        row.kind  = ROW_ITEM;
        row.req   = '{cmd, conn, size, draw};
        row.typed = 1'b1;
        row.want  = '{status, oc, os, occ};
        directed.push_back(row);
    endtask

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        directed.push_back(row);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_reply();
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 97 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_cycle % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        queue_op_t req;
        reply_t    none;
        int        phase, k, enq_pct;
        logic [CAP_W-1:0]    cap_pick;
        logic [POLICY_W-1:0] pol_pick;

        none = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        //          cmd      conn      size      draw      status    conn      size      occ
        add_checked(CMD_DEQ, 0,        0,        0,        ST_EMPTY, 0,        0,        0);
        add_checked(CMD_ENQ, CONN_MAX, SIZE_MAX, DRAW_MAX, ST_DONE,  0,        0,        1);
        add_checked(CMD_ENQ, 0,        0,        0,        ST_DONE,  0,        0,        2);
        add_checked(CMD_DEQ, 0,        0,        DRAW_MAX, ST_DONE,  CONN_MAX, SIZE_MAX, 1);
        add_checked(CMD_DEQ, 0,        0,        0,        ST_DONE,  0,        0,        0);
        add_reg(REG_CAPACITY, 5'd1);
        add_checked(CMD_ENQ, 16'h1234, 31'd5,    0,        ST_DONE,  0,        0,        1);
        add_checked(CMD_ENQ, 16'h4321, 31'd6,    0,        ST_FULL,  0,        0,        1);
        add_checked(CMD_DEQ, 0,        0,        0,        ST_DONE,  16'h1234, 31'd5,    0);
        add_reg(REG_CAPACITY, 5'd0);
        add_checked(CMD_ENQ, 16'h00aa, 31'd9,    0,        ST_DONE,  0,        0,        1);
        add_checked(CMD_ENQ, 16'h00bb, 31'd9,    0,        ST_FULL,  0,        0,        1);
        add_reg(REG_CAPACITY, 5'd31);
        add_reg(REG_POLICY, {3'b000, POL_SSF});
        add_item(CMD_ENQ, 16'h0001, 31'd50, 0);
        add_item(CMD_ENQ, 16'h0002, 31'd10, 0);
        add_item(CMD_ENQ, 16'h0003, 31'd50, 0);
        add_item(CMD_ENQ, 16'h0004, 31'd0,  0);
        add_item(CMD_ENQ, 16'h0005, SIZE_MAX, 0);
        add_item(CMD_DEQ, 0, 0, 0);
        add_item(CMD_DEQ, 0, 0, 0);
        add_reg(REG_POLICY, {3'b000, POL_RANDOM});
        add_item(CMD_DEQ, 0, 0, DRAW_MAX);
        add_item(CMD_ENQ, 16'h0007, 31'd20, 0);
        add_item(CMD_DEQ, 0, 0, 16'd1);
        add_reg(REG_POLICY, {3'b111, POL_UNUSED});
        add_item(CMD_DEQ, 0, 0, DRAW_MAX);
        add_reg(REG_SPARE, '1);
        add_reg(REG_CAPACITY, 5'd3);
        add_item(CMD_ENQ, 16'h0101, 31'd3, 0);
        add_item(CMD_ENQ, 16'h0102, 31'd2, 0);
        add_item(CMD_ENQ, 16'h0103, 31'd1, 0);
        add_checked(CMD_ENQ, 16'h0104, 31'd0, 0, ST_FULL, 0, 0, 3);
        add_item(CMD_DEQ, 0, 0, 0);

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_REG)
                write_reg(directed[r].idx, directed[r].data);
            else
                send_request(directed[r].req, directed[r].typed, directed[r].want);
        end

        enq_pct = 50;
        for (phase = 0; phase < 12; phase++) begin
            case (phase)
                0: cap_pick = 5'd16;
                1: cap_pick = 5'd1;
                2: cap_pick = 5'd31;
                3: cap_pick = 5'd0;
                4: cap_pick = 5'd2;
                default: cap_pick = ($urandom_range(0, 5) == 0) ?
                                    CAP_W'($urandom_range(17, 31)) :
                                    CAP_W'($urandom_range(1, 16));
            endcase
            if (phase < 4)
                pol_pick = POLICY_W'(phase);
            else if ($urandom_range(0, 2) == 0)
                pol_pick = POLICY_W'($urandom_range(0, 3));
            else
                pol_pick = POLICY_W'($urandom_range(1, 2));
            write_reg(REG_CAPACITY, cap_pick);
            write_reg(REG_POLICY, {3'($urandom_range(0, 7)), pol_pick});
            for (k = 0; k < 92; k++) begin
                if (k % 16 == 0) begin
                    case ($urandom_range(0, 2))
                        0: enq_pct = 85;
                        1: enq_pct = 50;
                        default: enq_pct = 25;
                    endcase
                end
                if (phase == 2 && k == 30)
                    hold_req <= 1'b1;
                req.cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                req.conn = CONN_W'($urandom);
                case ($urandom_range(0, 9))
                    0: req.size = '0;
                    1: req.size = SIZE_MAX;
                    2, 3, 4, 5: req.size = SIZE_W'($urandom_range(0, 7));
                    6, 7: req.size = SIZE_W'($urandom_range(0, 1000));
                    default: req.size = SIZE_W'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: req.draw = '0;
                    1: req.draw = DRAW_MAX;
                    default: req.draw = DRAW_W'($urandom);
                endcase
                send_request(req, 1'b0, none);
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/rqf_pkg.sv
rtl/rqf_mod.sv
rtl/rqf_dpath.sv
rtl/rqf_ctrl.sv
rtl/request_queue_fifo_sff_random_top.sv
verif/tb.sv
